// ----- hdl/dabs_pkg.sv -----
// ----------------------------------------------------------------------------
// dabs_pkg: shared types and constants
// Table geometry, command codes, register indexes and search stage word.
// ----------------------------------------------------------------------------
package dabs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int ENTRY_W     = 48;
    localparam int KEY_W       = 32;
    localparam int SCALE_W     = 16;
    // one probe per halving of the interval, plus one to settle
    localparam int STEPS       = ADDR_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd10000;

    typedef enum logic [1:0] {
        CMD_LOAD_X = 2'd0,
        CMD_LOAD_Y = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_X_COUNT   = 2'd0;
    localparam logic [1:0] REG_Y_COUNT   = 2'd1;
    localparam logic [1:0] REG_KEY_SCALE = 2'd2;

    // word carried down the search stages of one axis
    typedef struct packed {
        logic                      ld;
        logic [ADDR_W-1:0]         idx;
        logic [ENTRY_W-1:0]        val;
        logic signed [ENTRY_W-1:0] s;
        logic                      above;
        logic                      below;
        logic [COUNT_W-1:0]        lo;
        logic [COUNT_W-1:0]        hi;
        logic [ADDR_W-1:0]         mid;
    } step_t;

endpackage

// ----- hdl/dabs_axis.sv -----
// ----------------------------------------------------------------------------
// dabs_axis: pipelined bracket search in one table
// Range check, one probe per stage, then the equality fix-up. Each stage
// keeps its own copy of the table, written as a load word passes it.
// ----------------------------------------------------------------------------
module dabs_axis
    import dabs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_ld,
    input  logic [ADDR_W-1:0]         in_idx,
    input  logic [ENTRY_W-1:0]        in_val,
    input  logic signed [ENTRY_W-1:0] in_s,
    input  logic [COUNT_W-1:0]        count,
    output logic [ADDR_W-1:0]         res_lo,
    output logic [ADDR_W-1:0]         res_hi
);

    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] n_last;

    always_comb
    begin
        if (count == '0)
            n = COUNT_W'(1);
        else if (32'(count) > TABLE_DEPTH)
            n = COUNT_W'(TABLE_DEPTH);
        else
            n = count;
        n_last = n - COUNT_W'(1);
    end

    // range check stage
    logic [ENTRY_W-1:0] mem_a [TABLE_DEPTH];
    step_t              a_reg;
    step_t              a_next;
    logic signed [ENTRY_W-1:0] rd_last_reg;
    logic signed [ENTRY_W-1:0] rd_first_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_ld)
                mem_a[in_idx] <= in_val;
            rd_last_reg  <= $signed(mem_a[n_last[ADDR_W-1:0]]);
            rd_first_reg <= $signed(mem_a[0]);
        end
    end

    always_comb
    begin
        a_next     = '0;
        a_next.ld  = in_ld;
        a_next.idx = in_idx;
        a_next.val = in_val;
        a_next.s   = in_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_reg <= '0;
        else if (adv)
            a_reg <= a_next;
    end

    step_t st_in [STEPS+1];

    always_comb
    begin
        st_in[0]       = a_reg;
        st_in[0].above = a_reg.s > rd_last_reg;
        st_in[0].below = a_reg.s < rd_first_reg;
        st_in[0].lo    = '0;
        st_in[0].hi    = n;
        st_in[0].mid   = n[ADDR_W:1];
    end

    // probe stages
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [ENTRY_W-1:0]        mem [TABLE_DEPTH];
        step_t                     st_reg;
        logic signed [ENTRY_W-1:0] rd_reg;
        logic [COUNT_W-1:0]        mid_w;
        logic [COUNT_W-1:0]        lo_n;
        logic [COUNT_W-1:0]        hi_n;
        logic [COUNT_W:0]          sum;
        logic [COUNT_W-1:0]        nmid;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (st_in[k].ld)
                    mem[st_in[k].idx] <= st_in[k].val;
                rd_reg <= $signed(mem[st_in[k].mid]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_reg <= '0;
            else if (adv)
                st_reg <= st_in[k];
        end

        always_comb
        begin
            mid_w = {1'b0, st_reg.mid};
            lo_n  = st_reg.lo;
            hi_n  = st_reg.hi;
            if (rd_reg <= st_reg.s && mid_w > st_reg.lo)
                lo_n = mid_w;
            if (rd_reg >= st_reg.s && mid_w < st_reg.hi)
                hi_n = mid_w;
            sum  = {1'b0, lo_n} + {1'b0, hi_n};
            nmid = sum[COUNT_W:1];
            if (nmid >= n)
                nmid = n_last;
            st_in[k+1]     = st_reg;
            st_in[k+1].lo  = lo_n;
            st_in[k+1].hi  = hi_n;
            st_in[k+1].mid = nmid[ADDR_W-1:0];
        end
    end

    // equality fix-up stage
    logic [ENTRY_W-1:0]        mem_c [TABLE_DEPTH];
    logic [COUNT_W-1:0]        hi_c;
    step_t                     c_reg;
    step_t                     c_next;
    logic signed [ENTRY_W-1:0] rd_lo_reg;
    logic signed [ENTRY_W-1:0] rd_hi_reg;

    assign hi_c = (st_in[STEPS].hi >= n) ? n_last : st_in[STEPS].hi;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (st_in[STEPS].ld)
                mem_c[st_in[STEPS].idx] <= st_in[STEPS].val;
            rd_lo_reg <= $signed(mem_c[st_in[STEPS].lo[ADDR_W-1:0]]);
            rd_hi_reg <= $signed(mem_c[hi_c[ADDR_W-1:0]]);
        end
    end

    always_comb
    begin
        c_next    = st_in[STEPS];
        c_next.hi = hi_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg <= '0;
        else if (adv)
            c_reg <= c_next;
    end

    logic [COUNT_W-1:0]        lo_f;
    logic [COUNT_W-1:0]        hi_f;
    logic signed [ENTRY_W-1:0] rd_hi_f;

    always_comb
    begin
        hi_f    = c_reg.hi;
        rd_hi_f = rd_hi_reg;
        lo_f    = c_reg.lo;
        if (c_reg.s == rd_lo_reg)
        begin
            hi_f    = c_reg.lo;
            rd_hi_f = rd_lo_reg;
        end
        if (c_reg.s == rd_hi_f)
            lo_f = hi_f;
        priority if (c_reg.above)
        begin
            res_lo = n_last[ADDR_W-1:0];
            res_hi = n_last[ADDR_W-1:0];
        end
        else if (c_reg.below)
        begin
            res_lo = '0;
            res_hi = '0;
        end
        else
        begin
            res_lo = lo_f[ADDR_W-1:0];
            res_hi = hi_f[ADDR_W-1:0];
        end
    end

endmodule

// ----- hdl/dual_axis_bracket_search.sv -----
// ----------------------------------------------------------------------------
// dual_axis_bracket_search: bracket two scaled keys in two sorted tables
// Load words fill the x and y tables; query words return index brackets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready): one word per accepted edge. cmd selects a
//   load of the x or y table (entry_index, entry_value) or a query
//   (key_x, key_y). Loads and unused commands give no output word.
//   Output channel (valid/ready): one word per query, carrying x_low,
//   x_high, y_low, y_high, in query order.
//   Registers (APB, 0x0 x_count, 0x4 y_count, 0x8 key_scale) are to be
//   written only while the block is idle; the block does not enforce it.
//   Pipeline: key multiply, range check, nine probe stages, equality
//   fix-up and the output register. Throughput: one word per cycle unless
//   the output stalls; the probe chain is fully pipelined and each stage
//   reads its own copy of the table.
//   Reset clears all valid bits and restores the registers; table contents
//   are undefined until loaded.
//   A stalled receiver freezes the whole pipeline; ready drops until the
//   output word is taken, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module dual_axis_bracket_search
    import dabs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input words
    input  logic                      valid,
    output logic                      ready,
    input  logic [1:0]                cmd,
    input  logic [ADDR_W-1:0]         entry_index,
    input  logic signed [ENTRY_W-1:0] entry_value,
    input  logic signed [KEY_W-1:0]   key_x,
    input  logic signed [KEY_W-1:0]   key_y,
    // output words
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ADDR_W-1:0]         x_low,
    output logic [ADDR_W-1:0]         x_high,
    output logic [ADDR_W-1:0]         y_low,
    output logic [ADDR_W-1:0]         y_high,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int QDEPTH = STEPS + 2;

    // ---- registers ----
    logic [COUNT_W-1:0] x_count_reg;
    logic [COUNT_W-1:0] y_count_reg;
    logic [SCALE_W-1:0] key_scale_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg   <= COUNT_RESET;
            y_count_reg   <= COUNT_RESET;
            key_scale_reg <= SCALE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_X_COUNT:   x_count_reg   <= pwdata[COUNT_W-1:0];
                REG_Y_COUNT:   y_count_reg   <= pwdata[COUNT_W-1:0];
                REG_KEY_SCALE: key_scale_reg <= pwdata[SCALE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_X_COUNT:   prdata = {{(32-COUNT_W){1'b0}}, x_count_reg};
            REG_Y_COUNT:   prdata = {{(32-COUNT_W){1'b0}}, y_count_reg};
            REG_KEY_SCALE: prdata = {{(32-SCALE_W){1'b0}}, key_scale_reg};
            default:       prdata = '0;
        endcase
    end

    // ---- pipeline advance: whole chain moves unless the output word waits
    logic adv;
    logic out_valid_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign ready = adv;

    // ---- stage 0: decode and key scaling
    logic                      acc;
    logic                      q0_reg;
    logic                      ldx_reg;
    logic                      ldy_reg;
    logic [ADDR_W-1:0]         idx_reg;
    logic [ENTRY_W-1:0]        val_reg;
    logic signed [ENTRY_W-1:0] sx_reg;
    logic signed [ENTRY_W-1:0] sy_reg;
    logic                      idx_ok;
    logic signed [SCALE_W:0]   scale_s;
    logic signed [ENTRY_W-1:0] sx_w;
    logic signed [ENTRY_W-1:0] sy_w;

    assign acc     = valid && ready;
    assign idx_ok  = 32'(entry_index) < TABLE_DEPTH;
    assign scale_s = $signed({1'b0, key_scale_reg});

    // 32 x 17 signed product, operands sign-extended so nothing is lost;
    // it always fits the 48-bit entry format
    assign sx_w = ENTRY_W'(key_x) * ENTRY_W'(scale_s);
    assign sy_w = ENTRY_W'(key_y) * ENTRY_W'(scale_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_reg  <= 1'b0;
            ldx_reg <= 1'b0;
            ldy_reg <= 1'b0;
        end
        else if (adv)
        begin
            q0_reg  <= acc && (cmd == CMD_QUERY);
            ldx_reg <= acc && (cmd == CMD_LOAD_X) && idx_ok;
            ldy_reg <= acc && (cmd == CMD_LOAD_Y) && idx_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg <= entry_index;
            val_reg <= entry_value;
            sx_reg  <= sx_w;
            sy_reg  <= sy_w;
        end
    end

    // ---- query valid bits travelling beside the search stages
    logic [QDEPTH-1:0] qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qv_reg <= '0;
        else if (adv)
            qv_reg <= {qv_reg[QDEPTH-2:0], q0_reg};
    end

    // ---- one search pipeline per axis
    logic [ADDR_W-1:0] xl_w, xh_w, yl_w, yh_w;

    dabs_axis u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_ld  (ldx_reg),
        .in_idx (idx_reg),
        .in_val (val_reg),
        .in_s   (sx_reg),
        .count  (x_count_reg),
        .res_lo (xl_w),
        .res_hi (xh_w)
    );

    dabs_axis u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_ld  (ldy_reg),
        .in_idx (idx_reg),
        .in_val (val_reg),
        .in_s   (sy_reg),
        .count  (y_count_reg),
        .res_lo (yl_w),
        .res_hi (yh_w)
    );

    // ---- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= qv_reg[QDEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_low  <= xl_w;
            x_high <= xh_w;
            y_low  <= yl_w;
            y_high <= yh_w;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
